FILE: sv/alr_pkg.sv
// shared types, codes and constants of the antialiased line rasterizer
package alr_pkg;

  // default geometry
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // fixed field widths
  localparam int SCREEN_W  = 12;
  localparam int COLOR_W   = 32;
  localparam int COV_W     = 9;
  localparam int CFG_IDX_W = 2;

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 12'd480;

  // coverage levels
  localparam logic [COV_W-1:0] COV_FULL = 9'd256;
  localparam logic [COV_W-1:0] COV_HALF = 9'd128;
  localparam logic [COV_W-1:0] COV_NONE = 9'd0;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_INTERIOR,
    PH_LAST
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWAP,
    ST_ORDER,
    ST_DIV,
    ST_PIX1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic   latch_in;
    logic   swap;
    logic   order;
    logic   emit;
    logic   second;
    phase_e phase;
  } alr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more_cols;
    logic div_done;
  } alr_status_t;

endpackage

FILE: sv/alr_div.sv
// restoring divider for the slope magnitude, one quotient bit per cycle
module alr_div #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] numer_i,
  input  logic [COORD_BITS-1:0] denom_i,
  output logic                  done_o,
  output logic [FRAC_BITS:0]    quot_o
);
  import alr_pkg::*;

  localparam int QW    = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(QW + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [COORD_BITS:0]   rem_q;
  logic [COORD_BITS-1:0] den_q;
  logic [QW-1:0]         quot_q;

  logic [COORD_BITS:0] trial;
  logic                ge;
  logic                last_bit;

  // the integer bit uses the numerator as is, fraction bits shift first
  always_comb begin
    trial    = (cnt_q == '0) ? rem_q : {rem_q[COORD_BITS-1:0], 1'b0};
    ge       = trial >= {1'b0, den_q};
    last_bit = cnt_q == CNT_W'(QW - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_bit;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_bit) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, numer_i};
      den_q <= denom_i;
    end else if (busy_q) begin
      rem_q  <= ge ? (trial - {1'b0, den_q}) : trial;
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: sv/alr_dp.sv
// datapath: endpoint setup, slope, row accumulator, pixel and clipping
module alr_dp #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  alr_pkg::alr_cmd_t                     cmd_i,
  output alr_pkg::alr_status_t                  status_o,
  input  logic signed [COORD_BITS-1:0]          start_x_i,
  input  logic signed [COORD_BITS-1:0]          start_y_i,
  input  logic signed [COORD_BITS-1:0]          end_x_i,
  input  logic signed [COORD_BITS-1:0]          end_y_i,
  input  logic [alr_pkg::COLOR_W-1:0]           line_color_i,
  input  logic                                  cfg_we_i,
  input  logic [alr_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [alr_pkg::SCREEN_W-1:0]          cfg_wdata_i,
  output logic signed [COORD_BITS-1:0]          pixel_x_o,
  output logic signed [COORD_BITS-1:0]          pixel_y_o,
  output logic [alr_pkg::COV_W-1:0]             coverage_o,
  output logic [alr_pkg::COLOR_W-1:0]           pixel_color_o,
  output logic                                  visible_o,
  output logic                                  last_o
);
  import alr_pkg::*;

  localparam int C       = COORD_BITS;
  localparam int F       = FRAC_BITS;
  localparam int ACC_W   = C + F;
  localparam int SLOPE_W = F + 2;
  localparam int CMP_W   = (C > SCREEN_W) ? C : SCREEN_W;

  // configuration
  logic [SCREEN_W-1:0] width_q;
  logic [SCREEN_W-1:0] height_q;

  // line setup
  logic signed [C-1:0]       ax_q, ay_q, bx_q, by_q;
  logic [COLOR_W-1:0]        color_q;
  logic                      steep_q;
  logic signed [C-1:0]       first_col_q, first_row_q, final_col_q, final_row_q;
  logic signed [C-1:0]       column_q;
  logic                      dy_neg_q;
  logic                      dx_zero_q;
  logic signed [SLOPE_W-1:0] slope_q;
  logic signed [ACC_W-1:0]   acc_q;

  // output register payload
  logic signed [C-1:0] pix_x_q, pix_y_q;
  logic [COV_W-1:0]    cov_q;
  logic [COLOR_W-1:0]  pcolor_q;
  logic                vis_q;
  logic                last_q;

  // swap stage
  logic signed [C:0]   sdx, sdy, ndx, ndy;
  logic [C-1:0]        adx, ady;
  logic                steep_now;

  // order stage
  logic                swap_ends;
  logic signed [C-1:0] c0, r0, c1, r1;
  logic signed [C:0]   span, rise, nrise;
  logic [C-1:0]        dx, abs_dy;

  // divider
  logic        div_done;
  logic [F:0]  quot;
  logic [F+1:0] mag;

  // pixel
  logic signed [C:0]       col_w, row_base, row, px, py;
  logic [COV_W-1:0]        cov0, cov1;
  logic [7:0]              f8;
  logic                    vis;
  logic signed [ACC_W-1:0] acc_base, slope_ext;

  // column after the current one, signed
  logic signed [C:0]       col_next;

  always_comb begin
    sdx       = {bx_q[C-1], bx_q} - {ax_q[C-1], ax_q};
    sdy       = {by_q[C-1], by_q} - {ay_q[C-1], ay_q};
    ndx       = -sdx;
    ndy       = -sdy;
    adx       = sdx[C] ? ndx[C-1:0] : sdx[C-1:0];
    ady       = sdy[C] ? ndy[C-1:0] : sdy[C-1:0];
    steep_now = ady > adx;
  end

  always_comb begin
    swap_ends = ax_q > bx_q;
    c0        = swap_ends ? bx_q : ax_q;
    r0        = swap_ends ? by_q : ay_q;
    c1        = swap_ends ? ax_q : bx_q;
    r1        = swap_ends ? ay_q : by_q;
    span      = {c1[C-1], c1} - {c0[C-1], c0};
    rise      = {r1[C-1], r1} - {r0[C-1], r0};
    nrise     = -rise;
    dx        = span[C-1:0];
    abs_dy    = rise[C] ? nrise[C-1:0] : rise[C-1:0];
  end

  alr_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.order),
    .numer_i(abs_dy),
    .denom_i(dx),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign mag = {1'b0, quot};

  // pixel of the current column
  always_comb begin
    f8 = acc_q[F-1 -: 8];
    case (cmd_i.phase)
      PH_FIRST: begin
        col_w    = {first_col_q[C-1], first_col_q};
        row_base = {first_row_q[C-1], first_row_q};
        cov0     = COV_HALF;
        cov1     = COV_NONE;
      end
      PH_INTERIOR: begin
        col_w    = {column_q[C-1], column_q};
        row_base = {acc_q[ACC_W-1], acc_q[ACC_W-1:F]};
        cov0     = COV_FULL - {1'b0, f8};
        cov1     = {1'b0, f8};
      end
      default: begin
        col_w    = {final_col_q[C-1], final_col_q};
        row_base = {final_row_q[C-1], final_row_q};
        cov0     = COV_HALF;
        cov1     = COV_NONE;
      end
    endcase
    row = cmd_i.second ? (row_base + 1'b1) : row_base;
    px  = steep_q ? row : col_w;
    py  = steep_q ? col_w : row;
    vis = !px[C] && !py[C] &&
          (CMP_W'(px[C-1:0]) < CMP_W'(width_q)) &&
          (CMP_W'(py[C-1:0]) < CMP_W'(height_q));
  end

  always_comb begin
    acc_base  = (cmd_i.phase == PH_FIRST) ? {first_row_q, {F{1'b0}}} : acc_q;
    slope_ext = {{(ACC_W - SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q};
  end

  assign col_next           = {column_q[C-1], column_q} + 1'b1;
  assign status_o.div_done  = div_done;
  assign status_o.more_cols = col_next < $signed({final_col_q[C-1], final_col_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      ax_q    <= start_x_i;
      ay_q    <= start_y_i;
      bx_q    <= end_x_i;
      by_q    <= end_y_i;
      color_q <= line_color_i;
    end
    if (cmd_i.swap) begin
      steep_q <= steep_now;
      if (steep_now) begin
        ax_q <= ay_q;
        ay_q <= ax_q;
        bx_q <= by_q;
        by_q <= bx_q;
      end
    end
    if (cmd_i.order) begin
      first_col_q <= c0;
      first_row_q <= r0;
      final_col_q <= c1;
      final_row_q <= r1;
      column_q    <= c0;
      acc_q       <= '0;
      dy_neg_q    <= rise[C];
      dx_zero_q   <= dx == '0;
    end
    if (div_done) begin
      if (dx_zero_q) begin
        slope_q <= '0;
      end else begin
        slope_q <= dy_neg_q ? -mag : mag;
      end
    end
    if (cmd_i.emit) begin
      pix_x_q  <= px[C-1:0];
      pix_y_q  <= py[C-1:0];
      cov_q    <= cmd_i.second ? cov1 : cov0;
      pcolor_q <= color_q;
      vis_q    <= vis;
      last_q   <= cmd_i.second && (cmd_i.phase == PH_LAST);
      if (cmd_i.second && (cmd_i.phase != PH_LAST)) begin
        column_q <= column_q + 1'b1;
        acc_q    <= acc_base + slope_ext;
      end
    end
  end

  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign coverage_o    = cov_q;
  assign pixel_color_o = pcolor_q;
  assign visible_o     = vis_q;
  assign last_o        = last_q;

endmodule

FILE: sv/alr_ctrl.sv
// controller: load sequencing, column phase and output register valid
module alr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 cmd_i,
  input  logic                 out_stall_i,
  input  alr_pkg::alr_status_t status_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output alr_pkg::alr_cmd_t    cmd_o
);
  import alr_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   active_q, active_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || (active_q && !out_free);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    active_d = active_q;
    cmd_o    = '0;
    cmd_o.phase = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd_i == CMD_LOAD) begin
            cmd_o.latch_in = 1'b1;
            active_d       = 1'b1;
            phase_d        = PH_FIRST;
            state_d        = ST_SWAP;
          end else if (active_q) begin
            cmd_o.emit = 1'b1;
            state_d    = ST_PIX1;
          end
        end
      end
      ST_SWAP: begin
        cmd_o.swap = 1'b1;
        state_d    = ST_ORDER;
      end
      ST_ORDER: begin
        cmd_o.order = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_PIX1: begin
        if (out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.second = 1'b1;
          state_d      = ST_IDLE;
          if (phase_q == PH_LAST) begin
            active_d = 1'b0;
            phase_d  = PH_FIRST;
          end else begin
            phase_d = status_i.more_cols ? PH_INTERIOR : PH_LAST;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/antialiased_line_rasterizer_top.sv
// top level of the antialiased line rasterizer
// Antialiased line rasterizer after Xiaolin Wu, for integer endpoints. A load item (cmd 0)
// latches two endpoints and a color, exchanges x and y for steep lines, orders the endpoints
// by major coordinate and forms a signed Q1.FRAC_BITS slope with a restoring divider that
// makes one quotient bit a cycle; a load stalls the input through the swap, order and
// divide states. Each step item (cmd 1) then gives the two pixels of one major column as
// two output transfers, first endpoint column, interior columns, last endpoint column, with
// last set on the second pixel of the last column. Its two pixels go through the single
// output register, one pixel a cycle unless the output stalls; the next item waits for the
// second to leave unless the line has ended. A step while no line is active is taken and
// gives nothing. Coverage is in 1/256 units; visible is 0 outside the configured
// screen_width and screen_height (register 0 and 1 of the configuration port, which is
// always ready; the user must write it only while idle, which the block leaves unenforced).
module antialiased_line_rasterizer_top #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic signed [COORD_BITS-1:0]  start_x_i,
  input  logic signed [COORD_BITS-1:0]  start_y_i,
  input  logic signed [COORD_BITS-1:0]  end_x_i,
  input  logic signed [COORD_BITS-1:0]  end_y_i,
  input  logic [alr_pkg::COLOR_W-1:0]   line_color_i,
  // pixel output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS-1:0]  pixel_x_o,
  output logic signed [COORD_BITS-1:0]  pixel_y_o,
  output logic [alr_pkg::COV_W-1:0]     coverage_o,
  output logic [alr_pkg::COLOR_W-1:0]   pixel_color_o,
  output logic                          visible_o,
  output logic                          last_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [alr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [alr_pkg::SCREEN_W-1:0]  cfg_wdata_i
);
  import alr_pkg::*;

  alr_cmd_t    cmd;
  alr_status_t status;

  // registers take a transfer in any cycle
  assign cfg_ready_o = 1'b1;

  alr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd)
  );

  alr_dp #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .line_color_i (line_color_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .coverage_o   (coverage_o),
    .pixel_color_o(pixel_color_o),
    .visible_o    (visible_o),
    .last_o       (last_o)
  );

  // a new pixel never overwrites one still waiting at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("pixel loaded over a pending output transfer");

  // the slope lands only while a load holds the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> in_stall_o)
    else $error("divider finished outside a load");

  // the second pixel of a column goes out before the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && !cmd.second) |=> in_stall_o)
    else $error("input taken between the two pixels of a column");

endmodule
